>>> rtl/core/assembler_token_scanner_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the assembler token scanner
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSEMBLER_TOKEN_SCANNER_DEFINES_SVH
`define ASSEMBLER_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication: when a holds, c holds in that cycle.
`define ATS_ASSERT_NOW(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
		else $error("scanner assertion failed");

// Next-cycle implication: when a holds, c holds in the following cycle.
`define ATS_ASSERT_NEXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
		else $error("scanner assertion failed");

`endif

>>> rtl/core/ats_pkg.sv
// ---------------------------------------------------------------------------
// Assembler token scanner package
// Transaction types, scanner modes, commands and character codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ats_pkg;

	// Width of the reported line count
	localparam int LINE_W = 16;

	// Depth of the queue between classifier and result stage
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Character codes
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;

	typedef enum logic [1:0] {
		CMD_CHAR    = 2'd0,
		CMD_END     = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_BLANK   = 3'd0,
		MODE_WORD    = 3'd1,
		MODE_STRING  = 3'd2,
		MODE_BRACKET = 3'd3,
		MODE_COMMENT = 3'd4
	} mode_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] char_in;
	} in_item_t;

	typedef struct packed {
		logic              has_char;
		logic [7:0]        char_out;
		logic              token_end;
		logic [LINE_W-1:0] line_count;
		logic              last_of_step;
	} out_item_t;

	// One classified input: split marks a comma that first closes a word
	typedef struct packed {
		logic              split;
		logic              has_char;
		logic [7:0]        char_out;
		logic              token_end;
		logic [LINE_W-1:0] line_count;
	} entry_t;

endpackage

>>> rtl/core/ats_front.sv
// ---------------------------------------------------------------------------
// Assembler token scanner classifier
// Accepts one transaction a cycle unless the queue is full, tracks mode and
// line counter and queues a classified entry for every input with results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ats_front import ats_pkg::*; #(
	parameter int LINE_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	input  logic     q_full,
	output logic     q_push,
	output entry_t   q_data
);

	mode_t                mode_q;
	mode_t                mode_nxt;
	logic [LINE_BITS-1:0] line_q;
	logic [LINE_BITS-1:0] line_nxt;
	logic                 accept;
	logic                 emit;
	logic                 split;
	logic                 has;
	logic                 tok_end;
	logic [7:0]           ch;

	assign accept = push && !q_full;

	// Character classification and next mode
	always_comb begin
		mode_nxt = mode_q;
		line_nxt = line_q;
		emit     = 1'b0;
		split    = 1'b0;
		has      = 1'b0;
		tok_end  = 1'b0;
		ch       = item.char_in;
		unique case (item.command)
			CMD_RESTART: begin
				mode_nxt = MODE_BLANK;
				line_nxt = '0;
			end
			CMD_END: begin
				if (mode_q == MODE_WORD || mode_q == MODE_STRING ||
				    mode_q == MODE_BRACKET) begin
					emit    = 1'b1;
					tok_end = 1'b1;
				end
				mode_nxt = MODE_BLANK;
			end
			CMD_CHAR: begin
				if (mode_q == MODE_COMMENT) begin
					if (ch == CH_NL) mode_nxt = MODE_BLANK;
				end else begin
					priority if (ch == CH_NL) begin
						line_nxt = line_q + LINE_BITS'(1);
						emit     = 1'b1;
						has      = 1'b1;
						tok_end  = 1'b1;
						mode_nxt = MODE_BLANK;
					end else if (ch == CH_CR || ch == CH_TAB || ch == CH_SPACE) begin
						if (mode_q == MODE_WORD) begin
							emit     = 1'b1;
							tok_end  = 1'b1;
							mode_nxt = MODE_BLANK;
						end else if (mode_q == MODE_STRING || mode_q == MODE_BRACKET) begin
							emit = 1'b1;
							has  = 1'b1;
						end
					end else if (ch == CH_COMMA) begin
						emit = 1'b1;
						has  = 1'b1;
						if (mode_q != MODE_STRING && mode_q != MODE_BRACKET) begin
							split    = (mode_q == MODE_WORD);
							tok_end  = 1'b1;
							mode_nxt = MODE_BLANK;
						end
					end else if (ch == CH_QUOTE) begin
						if (mode_q == MODE_BLANK) begin
							emit     = 1'b1;
							has      = 1'b1;
							mode_nxt = MODE_STRING;
						end else if (mode_q == MODE_STRING) begin
							emit     = 1'b1;
							has      = 1'b1;
							tok_end  = 1'b1;
							mode_nxt = MODE_BLANK;
						end
					end else if (ch == CH_LBRACK) begin
						if (mode_q == MODE_BLANK) begin
							emit     = 1'b1;
							has      = 1'b1;
							mode_nxt = MODE_BRACKET;
						end else if (mode_q == MODE_STRING) begin
							emit = 1'b1;
							has  = 1'b1;
						end
					end else if (ch == CH_RBRACK) begin
						if (mode_q == MODE_BRACKET) begin
							emit     = 1'b1;
							has      = 1'b1;
							tok_end  = 1'b1;
							mode_nxt = MODE_BLANK;
						end else if (mode_q == MODE_STRING) begin
							emit = 1'b1;
							has  = 1'b1;
						end
					end else if (ch == CH_SEMI) begin
						if (mode_q == MODE_BLANK) begin
							mode_nxt = MODE_COMMENT;
						end else begin
							emit = 1'b1;
							has  = 1'b1;
						end
					end else begin
						emit = 1'b1;
						has  = 1'b1;
						if (mode_q == MODE_BLANK) mode_nxt = MODE_WORD;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Queue entry for the result stage
	always_comb begin
		q_push            = accept && emit;
		q_data.split      = split;
		q_data.has_char   = has;
		q_data.char_out   = has ? ch : 8'd0;
		q_data.token_end  = tok_end;
		q_data.line_count = LINE_W'(line_nxt);
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BLANK;
			line_q <= '0;
		end else if (accept) begin
			mode_q <= mode_nxt;
			line_q <= line_nxt;
		end
	end

endmodule

>>> rtl/core/ats_queue.sv
// ---------------------------------------------------------------------------
// Assembler token scanner entry queue
// Small first-in first-out buffer between classifier and result stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ats_queue import ats_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_data,
	output logic   full,
	input  logic   pop,
	output entry_t rd_data,
	output logic   empty
);

	entry_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (do_push && !do_pop)      count_q <= count_q + (QUEUE_AW+1)'(1);
			else if (do_pop && !do_push) count_q <= count_q - (QUEUE_AW+1)'(1);
		end
	end

endmodule

>>> rtl/core/ats_back.sv
// ---------------------------------------------------------------------------
// Assembler token scanner result stage
// Turns queue entries into result transactions, splitting a comma after a
// word into a word end and a comma token, through one output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assembler_token_scanner_defines.svh"

module ats_back import ats_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  entry_t    q_head,
	input  logic      q_empty,
	output logic      q_pop,
	output out_item_t result,
	output logic      empty,
	input  logic      pop
);

	out_item_t out_q;
	out_item_t out_nxt;
	logic      out_valid_q;
	logic      phase_q;
	logic      load;
	logic      first_half;

	assign load       = !out_valid_q || pop;
	assign first_half = q_head.split && !phase_q;
	assign q_pop      = load && !q_empty && !first_half;
	assign result     = out_q;
	assign empty      = !out_valid_q;

	// Result selection: the word end of a split entry comes first
	always_comb begin
		if (first_half) begin
			out_nxt.has_char     = 1'b0;
			out_nxt.char_out     = 8'd0;
			out_nxt.token_end    = 1'b1;
			out_nxt.line_count   = q_head.line_count;
			out_nxt.last_of_step = 1'b0;
		end else begin
			out_nxt.has_char     = q_head.has_char;
			out_nxt.char_out     = q_head.char_out;
			out_nxt.token_end    = q_head.token_end;
			out_nxt.line_count   = q_head.line_count;
			out_nxt.last_of_step = 1'b1;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load && !q_empty) out_q <= out_nxt;
	end

	// Output valid and split phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) phase_q <= first_half;
		end
	end

	// A pending second half keeps its entry at the queue head
	`ATS_ASSERT_NOW(a_phase_holds_head, clk, arst_n, phase_q, !q_empty && q_head.split)
	// While the second half is pending, the shown result is the word end
	`ATS_ASSERT_NOW(a_phase_shows_word_end, clk, arst_n, phase_q,
		out_valid_q && !out_q.last_of_step && out_q.token_end && !out_q.has_char)
	// Only the first half of a split entry is ever not the last of its step
	`ATS_ASSERT_NOW(a_not_last_is_split, clk, arst_n,
		out_valid_q && !out_q.last_of_step, phase_q)
	// Taking the word end brings out the comma token next
	`ATS_ASSERT_NEXT(a_comma_follows, clk, arst_n, phase_q && pop,
		out_valid_q && out_q.has_char && out_q.char_out == CH_COMMA && out_q.last_of_step)

endmodule

>>> rtl/core/assembler_token_scanner.sv
// ---------------------------------------------------------------------------
// Assembler token scanner
// Splits a source character stream into assembler tokens, one character
// per transaction, with token end marks and a wrapping line count.
// ---------------------------------------------------------------------------
//   Channel   Handshake        Payload
//   input     push / full      item   (command, char_in)
//   result    pop / empty      result (has_char, char_out, token_end,
//                                      line_count, last_of_step)
//
// One input transaction is taken every cycle while full is low; the
// classifier decides it in the cycle of acceptance.
// Each input yields zero, one or two results; a comma closing a word
// yields a word end and then a comma token, all other inputs at most one.
// A four-entry queue between classifier and result stage absorbs result
// stalls; full rises only when that queue is full.
// Reset clears the scanner mode, line counter, queue and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module assembler_token_scanner import ats_pkg::*; #(
	parameter int LINE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic   q_push;
	entry_t q_wr_data;
	logic   q_full;
	logic   q_pop;
	entry_t q_head;
	logic   q_empty;

	assign full = q_full;

	ats_front #(
		.LINE_BITS (LINE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wr_data)
	);

	ats_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	ats_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
